// File: rtl/core/tkp_pkg.sv
package tkp_pkg;

    localparam int K_MAX_DEFAULT     = 64;
    localparam int VOCAB_MAX_DEFAULT = 65536;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_DATA_W        = 17;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_INV_TEMPERATURE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COUNT_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NUCLEUS_THRESHOLD = 2'd2;

    localparam logic [15:0] INV_TEMPERATURE_RESET   = 16'd256;
    localparam logic [6:0]  KEEP_COUNT_LIMIT_RESET  = 7'd40;
    localparam logic [16:0] NUCLEUS_THRESHOLD_RESET = 17'd65536;

    localparam logic [24:0] EXP_CUTOFF_DIST = 25'd3072;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               last_logit;
        logic [15:0]        random_fraction;
    } in_item_t;

    typedef struct packed {
        logic [15:0] token_index;
        logic [6:0]  kept_in_nucleus;
    } out_item_t;

    typedef struct packed {
        logic [15:0] inv_temperature;
        logic [6:0]  keep_count_limit;
        logic [16:0] nucleus_threshold;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic [15:0]        index;
        logic               final_entry;
        logic [15:0]        frac;
    } cand_t;

    typedef struct packed {
        logic front_busy;
        logic queue_busy;
        logic back_busy;
    } status_t;

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd65280;
            4'd2:    r = 17'd65026;
            4'd3:    r = 17'd64772;
            4'd4:    r = 17'd64520;
            4'd5:    r = 17'd64268;
            4'd6:    r = 17'd64018;
            4'd7:    r = 17'd63768;
            4'd8:    r = 17'd63520;
            4'd9:    r = 17'd63272;
            4'd10:   r = 17'd63025;
            4'd11:   r = 17'd62780;
            4'd12:   r = 17'd62535;
            4'd13:   r = 17'd62291;
            4'd14:   r = 17'd62048;
            default: r = 17'd61806;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/top_k_top_p_token_sampler_top.sv
// A logit is taken whenever start is high and busy is low; busy stays low between logits.
// The last logit raises busy until its result: the kept entries drain through the queue
// into the weight pass (B_POP, B_MUL, B_EXP1, B_EXP2 per entry); then come B_THR1 and B_THR2,
// the cutoff pass (B_CUT_RD, B_CUT per entry) and the draw pass (B_PICK_RD, B_PICK per entry).
// The result is shown with done for one cycle; the receiver cannot stall it.
// Reset is asynchronous, active low; it clears the control state and restores the registers.
module top_k_top_p_token_sampler_top
    import tkp_pkg::*;
#(
    parameter int K_MAX     = K_MAX_DEFAULT,
    parameter int VOCAB_MAX = VOCAB_MAX_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  in_item_t               in_item,
    output logic                   done,
    output out_item_t              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    status_t status;
    logic    accept;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    cand_t   q_wdata;
    cand_t   q_rdata;

    assign busy   = status.front_busy || status.queue_busy || status.back_busy;
    assign accept = start && !busy;
    assign status.queue_busy = !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_temperature   <= INV_TEMPERATURE_RESET;
            cfg_reg.keep_count_limit  <= KEEP_COUNT_LIMIT_RESET;
            cfg_reg.nucleus_threshold <= NUCLEUS_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INV_TEMPERATURE:   cfg_reg.inv_temperature   <= cfg_data[15:0];
                REG_KEEP_COUNT_LIMIT:  cfg_reg.keep_count_limit  <= cfg_data[6:0];
                REG_NUCLEUS_THRESHOLD: cfg_reg.nucleus_threshold <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    tkp_front #(
        .K_MAX     (K_MAX),
        .VOCAB_MAX (VOCAB_MAX)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .item             (in_item),
        .keep_count_limit (cfg_reg.keep_count_limit),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_wdata),
        .front_busy       (status.front_busy)
    );

    tkp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    tkp_back #(
        .K_MAX (K_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .done      (done),
        .result    (result),
        .back_busy (status.back_busy)
    );

endmodule

// File: rtl/core/tkp_queue.sv
module tkp_queue
    import tkp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  cand_t wdata,
    input  logic  pop,
    output cand_t rdata,
    output logic  full,
    output logic  empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cand_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [NW-1:0]   cnt_reg;

    assign full  = (cnt_reg == NW'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + NW'(push && !full) - NW'(pop && !empty);
        end
    end

endmodule

// File: rtl/core/tkp_front.sv
module tkp_front
    import tkp_pkg::*;
#(
    parameter int K_MAX     = K_MAX_DEFAULT,
    parameter int VOCAB_MAX = VOCAB_MAX_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  in_item_t   item,
    input  logic [6:0] keep_count_limit,
    input  logic       q_full,
    output logic       q_push,
    output cand_t      q_data,
    output logic       front_busy
);

    localparam int CW = $clog2(K_MAX + 1);
    localparam int SEENW = $clog2(VOCAB_MAX + 1);

    typedef enum logic [1:0] {
        F_IDLE  = 2'b01,
        F_DRAIN = 2'b10
    } front_state_t;

    front_state_t        state_reg;
    logic signed [15:0]  vals_reg [K_MAX];
    logic [15:0]         idxs_reg [K_MAX];
    logic [CW-1:0]       count_reg;
    logic [SEENW-1:0]    seen_reg;
    logic [CW-1:0]       remain_reg;
    logic [15:0]         frac_reg;

    logic                gt [K_MAX];
    logic                insert_en;
    logic                drain_step;
    logic [CW-1:0]       count_after;
    logic [CW-1:0]       lim_clamped;
    logic [CW-1:0]       k_next;

    always_comb
    begin
        for (int i = 0; i < K_MAX; i++)
        begin
            gt[i] = (CW'(i) < count_reg) && (vals_reg[i] >= item.logit);
        end
    end

    assign insert_en  = accept && (seen_reg < SEENW'(VOCAB_MAX));
    assign drain_step = (state_reg == F_DRAIN) && !q_full;

    always_comb
    begin
        count_after = count_reg;
        if (insert_en && (count_reg < CW'(K_MAX)))
        begin
            count_after = count_reg + 1'b1;
        end
        if (keep_count_limit == 7'd0)
        begin
            lim_clamped = CW'(1);
        end
        else if ({2'b00, keep_count_limit} > 9'(K_MAX))
        begin
            lim_clamped = CW'(K_MAX);
        end
        else
        begin
            lim_clamped = CW'(keep_count_limit);
        end
        k_next = (lim_clamped < count_after) ? lim_clamped : count_after;
    end

    assign q_push     = drain_step;
    assign q_data     = '{value: vals_reg[0], index: idxs_reg[0],
                          final_entry: (remain_reg == CW'(1)), frac: frac_reg};
    assign front_busy = (state_reg != F_IDLE);

    always_ff @(posedge clk)
    begin
        if (insert_en)
        begin
            if (!gt[0])
            begin
                vals_reg[0] <= item.logit;
                idxs_reg[0] <= 16'(seen_reg);
            end
            for (int i = 1; i < K_MAX; i++)
            begin
                if (!gt[i])
                begin
                    if (gt[i-1])
                    begin
                        vals_reg[i] <= item.logit;
                        idxs_reg[i] <= 16'(seen_reg);
                    end
                    else
                    begin
                        vals_reg[i] <= vals_reg[i-1];
                        idxs_reg[i] <= idxs_reg[i-1];
                    end
                end
            end
        end
        else if (drain_step)
        begin
            for (int i = 0; i < K_MAX - 1; i++)
            begin
                vals_reg[i] <= vals_reg[i+1];
                idxs_reg[i] <= idxs_reg[i+1];
            end
        end
        if (accept)
        begin
            frac_reg <= item.random_fraction;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            count_reg  <= '0;
            seen_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= count_after;
                        if (insert_en)
                        begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                        if (item.last_logit)
                        begin
                            remain_reg <= k_next;
                            state_reg  <= F_DRAIN;
                        end
                    end
                end
                F_DRAIN:
                begin
                    if (drain_step)
                    begin
                        remain_reg <= remain_reg - 1'b1;
                        if (remain_reg == CW'(1))
                        begin
                            count_reg <= '0;
                            seen_reg  <= '0;
                            state_reg <= F_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/tkp_back.sv
module tkp_back
    import tkp_pkg::*;
#(
    parameter int K_MAX = K_MAX_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_empty,
    input  cand_t     q_data,
    output logic      q_pop,
    output logic      done,
    output out_item_t result,
    output logic      back_busy
);

    localparam int CW = $clog2(K_MAX + 1);
    localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int SW = 16 + CW;
    localparam int PW = SW + 17;

    typedef enum logic [12:0] {
        B_POP     = 13'b0000000000001,
        B_MUL     = 13'b0000000000010,
        B_EXP1    = 13'b0000000000100,
        B_EXP2    = 13'b0000000001000,
        B_THR1    = 13'b0000000010000,
        B_THR2    = 13'b0000000100000,
        B_CUT_RD  = 13'b0000001000000,
        B_CUT     = 13'b0000010000000,
        B_RMUL    = 13'b0000100000000,
        B_PICK_RD = 13'b0001000000000,
        B_PICK    = 13'b0010000000000,
        B_OUT     = 13'b0100000000000,
        B_SPARE   = 13'b1000000000000
    } back_state_t;

    back_state_t         state_reg;
    logic                first_reg;
    logic                last_reg;
    logic signed [15:0]  max_reg;
    logic [15:0]         diff_reg;
    logic [24:0]         d_reg;
    logic [16:0]         w1_reg;
    logic                wzero_reg;
    logic [3:0]          lo_sel_reg;
    logic [15:0]         frac_reg;
    logic [CW-1:0]       n_reg;
    logic [AW-1:0]       ptr_reg;
    logic [SW-1:0]       total_reg;
    logic [32:0]         prod_lo_reg;
    logic [PW-1:0]       prod_reg;
    logic [SW-1:0]       cum_reg;
    logic [CW-1:0]       cutoff_reg;
    logic [SW-1:0]       kept_reg;
    logic [SW-1:0]       r_reg;

    logic [15:0]         wmem [K_MAX];
    logic [15:0]         imem [K_MAX];
    logic [15:0]         w_rdata;
    logic [15:0]         i_rdata;

    logic signed [16:0]  diff_wide;
    logic [32:0]         d_full;
    logic [33:0]         w1_full;
    logic [33:0]         w2_full;
    logic [16:0]         w2;
    logic [15:0]         w_final;
    logic [SW-1:0]       cum_next;
    logic [PW-1:0]       cum_shift;
    logic [SW+15:0]      r_full;
    logic                at_last_entry;
    logic                at_cutoff_entry;

    assign q_pop     = (state_reg == B_POP) && !q_empty;
    assign back_busy = !((state_reg == B_POP) && first_reg);
    assign done      = (state_reg == B_OUT);
    assign result    = '{token_index: i_rdata, kept_in_nucleus: 7'(cutoff_reg)};

    always_comb
    begin
        diff_wide = first_reg ? 17'sd0 :
                    (17'(max_reg) - 17'(q_data.value));
        d_full    = 33'(32'(diff_reg) * 32'(cfg.inv_temperature)) + 33'd128;
        w1_full   = 34'(exp_int(d_reg[11:8])) * 34'(exp_hi(d_reg[7:4])) + 34'd32768;
        w2_full   = 34'(w1_reg) * 34'(exp_lo(lo_sel_reg)) + 34'd32768;
        w2        = w2_full[32:16];
        if (wzero_reg)
        begin
            w_final = 16'd0;
        end
        else if (w2 > 17'd65535)
        begin
            w_final = 16'hFFFF;
        end
        else
        begin
            w_final = w2[15:0];
        end
        cum_next        = cum_reg + SW'(w_rdata);
        cum_shift       = PW'({cum_next, 16'd0});
        r_full          = (SW + 16)'(frac_reg) * (SW + 16)'(kept_reg);
        at_last_entry   = (CW'(ptr_reg) == n_reg - CW'(1));
        at_cutoff_entry = (CW'(ptr_reg) == cutoff_reg - CW'(1));
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            imem[n_reg[AW-1:0]] <= q_data.index;
        end
        if (state_reg == B_EXP2)
        begin
            wmem[n_reg[AW-1:0]] <= w_final;
        end
        w_rdata <= wmem[ptr_reg];
        i_rdata <= imem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_POP:
            begin
                if (q_pop)
                begin
                    diff_reg <= diff_wide[15:0];
                    last_reg <= q_data.final_entry;
                    frac_reg <= q_data.frac;
                    if (first_reg)
                    begin
                        max_reg <= q_data.value;
                    end
                end
            end
            B_MUL:
            begin
                d_reg <= d_full[32:8];
            end
            B_EXP1:
            begin
                wzero_reg  <= (d_reg >= EXP_CUTOFF_DIST);
                w1_reg     <= w1_full[32:16];
                lo_sel_reg <= d_reg[3:0];
            end
            B_THR1:
            begin
                prod_lo_reg <= 33'(cfg.nucleus_threshold) * 33'(total_reg[15:0]);
            end
            B_THR2:
            begin
                prod_reg <= PW'(prod_lo_reg) +
                            (PW'(PW'(cfg.nucleus_threshold) *
                                 PW'(total_reg[SW-1:16])) << 16);
            end
            B_CUT:
            begin
                kept_reg <= cum_next;
            end
            B_RMUL:
            begin
                r_reg <= r_full[SW+15:16];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_POP;
            first_reg  <= 1'b1;
            n_reg      <= '0;
            ptr_reg    <= '0;
            total_reg  <= '0;
            cum_reg    <= '0;
            cutoff_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_POP:
                begin
                    if (q_pop)
                    begin
                        first_reg <= 1'b0;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL:
                begin
                    state_reg <= B_EXP1;
                end
                B_EXP1:
                begin
                    state_reg <= B_EXP2;
                end
                B_EXP2:
                begin
                    total_reg <= total_reg + SW'(w_final);
                    n_reg     <= n_reg + 1'b1;
                    state_reg <= last_reg ? B_THR1 : B_POP;
                end
                B_THR1:
                begin
                    state_reg <= B_THR2;
                end
                B_THR2:
                begin
                    ptr_reg   <= '0;
                    cum_reg   <= '0;
                    state_reg <= B_CUT_RD;
                end
                B_CUT_RD:
                begin
                    state_reg <= B_CUT;
                end
                B_CUT:
                begin
                    if ((cum_shift >= prod_reg) || at_last_entry)
                    begin
                        cutoff_reg <= CW'(ptr_reg) + CW'(1);
                        state_reg  <= B_RMUL;
                    end
                    else
                    begin
                        cum_reg   <= cum_next;
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= B_CUT_RD;
                    end
                end
                B_RMUL:
                begin
                    ptr_reg   <= '0;
                    cum_reg   <= '0;
                    state_reg <= B_PICK_RD;
                end
                B_PICK_RD:
                begin
                    state_reg <= B_PICK;
                end
                B_PICK:
                begin
                    if ((r_reg < cum_next) || at_cutoff_entry)
                    begin
                        state_reg <= B_OUT;
                    end
                    else
                    begin
                        cum_reg   <= cum_next;
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= B_PICK_RD;
                    end
                end
                B_OUT:
                begin
                    first_reg <= 1'b1;
                    n_reg     <= '0;
                    total_reg <= '0;
                    state_reg <= B_POP;
                end
                default:
                begin
                    state_reg <= B_POP;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cutoff_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT) |-> (cutoff_reg != '0) && (cutoff_reg <= n_reg))
        else $error("cutoff outside the kept candidates");
    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("candidate popped from an empty queue");
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");
    a_pick_before_cutoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT) |-> (CW'(ptr_reg) < cutoff_reg))
        else $error("picked entry lies past the cutoff");
`endif

endmodule
